// ===== rtl/crc32_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_pkg
// Register map, reset values and the byte-update function for the
// MSB-first CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_POLY    = 2'd0;
    localparam logic [1:0] REG_INIT    = 2'd1;
    localparam logic [1:0] REG_REFLECT = 2'd2;
    localparam logic [1:0] REG_INVERT  = 2'd3;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;

    typedef logic [CRC_W-1:0] crc_t;

    // XOR one byte into the top of the register, then eight shift steps
    function automatic crc_t crc32_absorb(input crc_t crc, input logic [BYTE_W-1:0] data,
                                          input crc_t poly);
        crc_t r;
        r = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (r[CRC_W-1])
                r = {r[CRC_W-2:0], 1'b0} ^ poly;
            else
                r = {r[CRC_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic crc_t crc32_reverse(input crc_t v);
        crc_t r;
        for (int k = 0; k < CRC_W; k++)
        begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crc32_msb_first_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_msb_first_engine
// Byte-stream CRC-32, MSB first, with programmable polynomial, initial value,
// output reversal and output inversion.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while in_stall is low. A byte is captured in
// the input register and then folded into the running CRC by one unrolled
// eight-step XOR network; a byte marked last places the finished CRC in the
// result register, so a result passes the input and result registers in turn.
// Non-last bytes never wait on the output side; a last byte waits only while
// the previous result is still held. Writing initial_value also restarts the
// running CRC; registers are to be written only while no message is in flight.
module crc32_msb_first_engine
    import crc32_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    // APB-style configuration port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // byte input
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire  [BYTE_W-1:0]   data_byte,
    input  wire                 last_byte,
    // result output
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [CRC_W-1:0]    crc_value
);

    crc_t               poly_reg;
    crc_t               init_reg;
    logic               reflect_reg;
    logic               invert_reg;
    crc_t               crc_reg;
    crc_t               crc_next;

    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               s1_last_reg;

    logic               res_valid_reg;
    crc_t               res_crc_reg;

    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic               s1_adv;
    logic               s1_load;
    crc_t               absorbed;
    crc_t               finished;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_POLY:    prdata = poly_reg;
            REG_INIT:    prdata = init_reg;
            REG_REFLECT: prdata = {{(DATA_W-1){1'b0}}, reflect_reg};
            REG_INVERT:  prdata = {{(DATA_W-1){1'b0}}, invert_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg    <= POLY_RESET;
            init_reg    <= INIT_RESET;
            reflect_reg <= 1'b1;
            invert_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_POLY:    poly_reg    <= pwdata;
                REG_INIT:    init_reg    <= pwdata;
                REG_REFLECT: reflect_reg <= pwdata[0];
                REG_INVERT:  invert_reg  <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // a non-last byte leaves no result, so it never waits on the output
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !res_valid_reg || !out_stall);
    assign s1_load  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s1_adv;

    always_comb
    begin
        absorbed = crc32_absorb(crc_reg, s1_byte_reg, poly_reg);
        finished = reflect_reg ? crc32_reverse(absorbed) : absorbed;
        if (invert_reg)
            finished = ~finished;
        crc_next = crc_reg;
        if (cfg_wr && (cfg_idx == REG_INIT))
            crc_next = pwdata;
        else if (s1_adv)
            crc_next = s1_last_reg ? init_reg : absorbed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= INIT_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg <= crc_next;
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv && s1_last_reg)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_adv && s1_last_reg)
            res_crc_reg <= finished;
    end

    assign out_valid = res_valid_reg;
    assign crc_value = res_crc_reg;

endmodule
`default_nettype wire

// ===== rtl/crc32_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_checker
// Port-level checks for the CRC-32 engine, bound to crc32_msb_first_engine.
// ----------------------------------------------------------------------------
module crc32_checker
    import crc32_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                psel,
    input wire                penable,
    input wire                pwrite,
    input wire  [ADDR_W-1:0]  paddr,
    input wire  [DATA_W-1:0]  pwdata,
    input wire  [DATA_W-1:0]  prdata,
    input wire                pready,
    input wire                in_stall,
    input wire                out_valid,
    input wire                out_stall,
    input wire  [CRC_W-1:0]   crc_value
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(crc_value))
        else $error("stalled result item changed");

    // input backs up only behind a held result
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

    a_no_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    // polynomial register reads back what was written
    a_poly_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[3:2] == REG_POLY)
        |=> !(psel && !pwrite && (paddr[3:2] == REG_POLY)) || (prdata == $past(pwdata)))
        else $error("polynomial readback mismatch");

endmodule

bind crc32_msb_first_engine crc32_checker u_crc32_checker (.*);
`default_nettype wire
